// ----- sv/bvw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Virtual wall force package
// Shared types, register indexes, microcode program and Q16.16 helpers.
// ----------------------------------------------------------------------------
package bvw_pkg;

    // Width of the exact accumulation and rounding datapath.
    localparam int ACC_W  = 51;
    localparam int STEP_W = 4;
    localparam int ADDR_W = 5;

    // Wall mode codes.
    typedef enum logic [1:0] {
        MODE_OUTSIDE = 2'd0,
        MODE_INSIDE  = 2'd1,
        MODE_BROKEN  = 2'd2
    } mode_t;

    // Configuration register indexes (word address).
    typedef enum logic [2:0] {
        REG_STIFFNESS  = 3'd0,
        REG_DAMP_IN    = 3'd1,
        REG_DAMP_OUT   = 3'd2,
        REG_THICKNESS  = 3'd3,
        REG_DAMP_OFFS  = 3'd4
    } reg_idx_t;

    // Hold conditions of a microcode step.
    typedef enum logic [1:0] {
        WT_NONE,
        WT_IN,
        WT_OUT
    } wait_t;

    // Multiplier operand selection.
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_NV0,
        MUL_NV1,
        MUL_NV2,
        MUL_SPRING,
        MUL_DAMP,
        MUL_MN0,
        MUL_MN1,
        MUL_MN2
    } mul_sel_t;

    // Accumulator operation.
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLR,
        ACC_ADD
    } acc_op_t;

    // Register write selection.
    typedef enum logic [2:0] {
        WR_NONE,
        WR_LOAD,
        WR_MODE,
        WR_SPRING_VN,
        WR_DAMP,
        WR_MAG,
        WR_FX,
        WR_FY_OUT
    } wr_sel_t;

    typedef struct packed {
        wait_t    wt;
        mul_sel_t mul;
        acc_op_t  acc;
        wr_sel_t  wr;
        logic     last;
        logic     fz_out;
    } ctrl_t;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(12);

    // Microcode program: one control word per step.
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t c;
        c = '{wt: WT_NONE, mul: MUL_NONE, acc: ACC_HOLD, wr: WR_NONE,
              last: 1'b0, fz_out: 1'b0};
        case (step)
            4'd0:
            begin
                c.wt  = WT_IN;
                c.wr  = WR_LOAD;
                c.acc = ACC_CLR;
            end
            4'd1:
            begin
                c.mul = MUL_NV0;
                c.wr  = WR_MODE;
            end
            4'd2:
            begin
                c.mul = MUL_NV1;
                c.acc = ACC_ADD;
            end
            4'd3:
            begin
                c.mul = MUL_NV2;
                c.acc = ACC_ADD;
            end
            4'd4:
            begin
                c.mul = MUL_SPRING;
                c.acc = ACC_ADD;
            end
            4'd5:
            begin
                c.wr = WR_SPRING_VN;
            end
            4'd6:
            begin
                c.mul = MUL_DAMP;
            end
            4'd7:
            begin
                c.wr = WR_DAMP;
            end
            4'd8:
            begin
                c.wr = WR_MAG;
            end
            4'd9:
            begin
                c.mul = MUL_MN0;
            end
            4'd10:
            begin
                c.mul = MUL_MN1;
                c.wr  = WR_FX;
            end
            4'd11:
            begin
                c.mul = MUL_MN2;
                c.wr  = WR_FY_OUT;
            end
            LAST_STEP:
            begin
                c.wt     = WT_OUT;
                c.fz_out = 1'b1;
                c.last   = 1'b1;
            end
            default:
            begin
                c.last = 1'b1;
            end
        endcase
        return c;
    endfunction

    // Round a Q32.32 product to Q16.16, half up (floor of (p + 2^15) / 2^16).
    function automatic logic signed [ACC_W-1:0] round_q(input logic signed [64:0] p);
        logic signed [64:0] t;
        logic signed [64:0] s;
        t = p + 65'sd32768;
        s = t >>> 16;
        return s[ACC_W-1:0];
    endfunction

    // Saturate to 32 bit signed.
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
        logic fits;
        fits = (&x[ACC_W-1:31]) | ~(|x[ACC_W-1:31]);
        if (fits)
        begin
            return x[31:0];
        end
        else if (x[ACC_W-1])
        begin
            return 32'sh8000_0000;
        end
        else
        begin
            return 32'sh7FFF_FFFF;
        end
    endfunction

endpackage

// ----- sv/bvw_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Virtual wall channels
// Valid/ready interfaces for haptic samples and force results.
// ----------------------------------------------------------------------------
interface bvw_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] depth;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] force_in_x;
    logic signed [31:0] force_in_y;
    logic signed [31:0] force_in_z;

    modport source (output valid, depth, normal_x, normal_y, normal_z,
                    vel_x, vel_y, vel_z, force_in_x, force_in_y, force_in_z,
                    input ready);
    modport sink (input valid, depth, normal_x, normal_y, normal_z,
                  vel_x, vel_y, vel_z, force_in_x, force_in_y, force_in_z,
                  output ready);
endinterface

interface bvw_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] force_out_x;
    logic signed [31:0] force_out_y;
    logic signed [31:0] force_out_z;
    logic [1:0]         mode_now;

    modport source (output valid, force_out_x, force_out_y, force_out_z, mode_now,
                    input ready);
    modport sink (input valid, force_out_x, force_out_y, force_out_z, mode_now,
                  output ready);
endinterface

// ----- sv/breakthrough_virtual_wall_force_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Haptic virtual wall with breakthrough
// Spring-damper force along the wall normal, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   sample (sink) takes one haptic sample per request: depth, normal, velocity
//   and the force gathered so far, all signed Q16.16. result (source) returns
//   the force with the wall effect added and the wall mode after the sample.
//   APB reads return the register values. Gains, thickness and damping offset
//   are written there by the user only while the block is idle (not enforced).
// Timing:
//   A sample is accepted at step 0 of a 13-step program. One shared 32x33
//   multiplier computes all eight products, one per step, so the next sample
//   is accepted only after the program has run through its last step.
//   The result sits in an output register, so the next sample is accepted
//   while it waits; if the receiver stalls, the last step holds until the
//   register frees.
// Reset:
//   Configuration registers clear to zero, the wall mode to inside, the step
//   counter to 0 and the result channel goes idle.
// ----------------------------------------------------------------------------
module breakthrough_virtual_wall_force_top (
    input  logic                        clk,
    input  logic                        rst_n,
    bvw_sample_if.sink                  sample,
    bvw_result_if.source                result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bvw_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import bvw_pkg::*;

    // Configuration registers.
    logic [30:0]        stiffness_reg;
    logic [30:0]        damp_in_reg;
    logic [30:0]        damp_out_reg;
    logic [30:0]        thickness_reg;
    logic signed [31:0] damp_offs_reg;

    // Sequencer state.
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    mode_t              mode_reg;
    mode_t              mode_next;
    logic               out_valid_reg;
    ctrl_t              ctrl;
    logic               hold;
    logic               advance;

    // Datapath registers.
    logic signed [31:0] depth_reg;
    logic signed [31:0] n_reg [3];
    logic signed [31:0] v_reg [3];
    logic signed [31:0] f_reg [3];
    logic signed [64:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic               spring_en_reg;
    logic               damp_en_reg;
    logic signed [31:0] spring_reg;
    logic signed [31:0] vn_reg;
    logic signed [31:0] damp_reg;
    logic signed [31:0] mag_reg;
    logic signed [31:0] fx_reg;
    logic signed [31:0] fy_reg;
    logic signed [31:0] out_x_reg;
    logic signed [31:0] out_y_reg;
    logic signed [31:0] out_z_reg;
    logic [1:0]         out_mode_reg;

    // Combinational datapath values.
    logic signed [31:0]      mul_a;
    logic signed [32:0]      mul_b;
    logic signed [ACC_W-1:0] prod_rnd;
    logic signed [31:0]      prod_sat;
    logic signed [31:0]      force_sum;
    logic signed [ACC_W-1:0] mag_sum;
    logic signed [32:0]      depth33;
    logic signed [32:0]      thick_sum;
    logic signed [32:0]      offs_diff;
    logic                    spring_en_next;
    logic                    damp_en_next;
    logic [1:0]              fsel;
    logic [31:0]             gain;

    // APB port: writes at the access phase, reads are combinational.
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[4:2])
            REG_STIFFNESS: prdata = {1'b0, stiffness_reg};
            REG_DAMP_IN:   prdata = {1'b0, damp_in_reg};
            REG_DAMP_OUT:  prdata = {1'b0, damp_out_reg};
            REG_THICKNESS: prdata = {1'b0, thickness_reg};
            REG_DAMP_OFFS: prdata = damp_offs_reg;
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiffness_reg <= '0;
            damp_in_reg   <= '0;
            damp_out_reg  <= '0;
            thickness_reg <= '0;
            damp_offs_reg <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[4:2])
                REG_STIFFNESS: stiffness_reg <= pwdata[30:0];
                REG_DAMP_IN:   damp_in_reg   <= pwdata[30:0];
                REG_DAMP_OUT:  damp_out_reg  <= pwdata[30:0];
                REG_THICKNESS: thickness_reg <= pwdata[30:0];
                REG_DAMP_OFFS: damp_offs_reg <= pwdata;
                default:       ;
            endcase
        end
    end

    // Control word decode and step sequencing.
    assign ctrl    = ucode(step_reg);
    assign hold    = ((ctrl.wt == WT_IN) && !sample.valid) ||
                     ((ctrl.wt == WT_OUT) && out_valid_reg && !result.ready);
    assign advance = !hold;

    assign sample.ready       = (ctrl.wt == WT_IN);
    assign result.valid       = out_valid_reg;
    assign result.force_out_x = out_x_reg;
    assign result.force_out_y = out_y_reg;
    assign result.force_out_z = out_z_reg;
    assign result.mode_now    = out_mode_reg;

    always_comb
    begin
        if (hold)
        begin
            step_next = step_reg;
        end
        else if (ctrl.last)
        begin
            step_next = '0;
        end
        else
        begin
            step_next = step_reg + STEP_W'(1);
        end
    end

    // Wall mode update from the latched depth.
    always_comb
    begin
        depth33        = 33'(depth_reg);
        thick_sum      = depth33 + $signed({2'b00, thickness_reg});
        offs_diff      = depth33 - 33'(damp_offs_reg);
        mode_next      = mode_reg;
        spring_en_next = 1'b0;
        if (mode_next == MODE_OUTSIDE && depth_reg < 0)
        begin
            mode_next = MODE_INSIDE;
        end
        if (mode_next == MODE_INSIDE)
        begin
            if (thick_sum[32])
            begin
                mode_next = MODE_BROKEN;
            end
            else if (depth_reg > 0)
            begin
                mode_next = MODE_OUTSIDE;
            end
            else
            begin
                spring_en_next = 1'b1;
            end
        end
        if (mode_next == MODE_BROKEN && depth_reg > 0)
        begin
            mode_next = MODE_OUTSIDE;
        end
        damp_en_next = offs_diff[32] && (mode_next != MODE_BROKEN);
    end

    // Damping gain follows the sign of the normal velocity; zero when damping is off.
    always_comb
    begin
        if (!damp_en_reg)
        begin
            gain = 32'd0;
        end
        else if (vn_reg < 0)
        begin
            gain = {1'b0, damp_in_reg};
        end
        else if (vn_reg > 0)
        begin
            gain = {1'b0, damp_out_reg};
        end
        else
        begin
            gain = 32'd0;
        end
    end

    // Multiplier operand selection.
    always_comb
    begin
        case (ctrl.mul)
            MUL_NV0:
            begin
                mul_a = n_reg[0];
                mul_b = 33'(v_reg[0]);
            end
            MUL_NV1:
            begin
                mul_a = n_reg[1];
                mul_b = 33'(v_reg[1]);
            end
            MUL_NV2:
            begin
                mul_a = n_reg[2];
                mul_b = 33'(v_reg[2]);
            end
            MUL_SPRING:
            begin
                mul_a = spring_en_reg ? $signed({1'b0, stiffness_reg}) : 32'sd0;
                mul_b = -33'(depth_reg);
            end
            MUL_DAMP:
            begin
                mul_a = $signed(gain);
                mul_b = -33'(vn_reg);
            end
            MUL_MN0:
            begin
                mul_a = mag_reg;
                mul_b = 33'(n_reg[0]);
            end
            MUL_MN1:
            begin
                mul_a = mag_reg;
                mul_b = 33'(n_reg[1]);
            end
            MUL_MN2:
            begin
                mul_a = mag_reg;
                mul_b = 33'(n_reg[2]);
            end
            default:
            begin
                mul_a = 32'sd0;
                mul_b = 33'sd0;
            end
        endcase
    end

    // Rounding of the product register and per-axis force sum.
    always_comb
    begin
        prod_rnd = round_q(prod_reg);
        prod_sat = sat32(prod_rnd);
        mag_sum  = ACC_W'(spring_reg) + ACC_W'(damp_reg);
        case (step_reg)
            4'd10:   fsel = 2'd0;
            4'd11:   fsel = 2'd1;
            default: fsel = 2'd2;
        endcase
        force_sum = sat32(ACC_W'(f_reg[fsel]) + prod_rnd);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            mode_reg      <= MODE_INSIDE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (advance && ctrl.wr == WR_MODE)
            begin
                mode_reg <= mode_next;
            end
            if (advance && ctrl.fz_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (ctrl.mul != MUL_NONE)
            begin
                prod_reg <= mul_a * mul_b;
            end
            case (ctrl.acc)
                ACC_CLR: acc_reg <= '0;
                ACC_ADD: acc_reg <= acc_reg + prod_rnd;
                default: ;
            endcase
            case (ctrl.wr)
                WR_LOAD:
                begin
                    depth_reg <= sample.depth;
                    n_reg[0]  <= sample.normal_x;
                    n_reg[1]  <= sample.normal_y;
                    n_reg[2]  <= sample.normal_z;
                    v_reg[0]  <= sample.vel_x;
                    v_reg[1]  <= sample.vel_y;
                    v_reg[2]  <= sample.vel_z;
                    f_reg[0]  <= sample.force_in_x;
                    f_reg[1]  <= sample.force_in_y;
                    f_reg[2]  <= sample.force_in_z;
                end
                WR_MODE:
                begin
                    spring_en_reg <= spring_en_next;
                    damp_en_reg   <= damp_en_next;
                end
                WR_SPRING_VN:
                begin
                    spring_reg <= prod_sat;
                    vn_reg     <= sat32(acc_reg);
                end
                WR_DAMP:
                begin
                    damp_reg <= prod_sat;
                end
                WR_MAG:
                begin
                    mag_reg <= sat32(mag_sum);
                end
                WR_FX:
                begin
                    fx_reg <= force_sum;
                end
                WR_FY_OUT:
                begin
                    fy_reg <= force_sum;
                end
                default: ;
            endcase
            if (ctrl.fz_out)
            begin
                out_x_reg    <= fx_reg;
                out_y_reg    <= fy_reg;
                out_z_reg    <= force_sum;
                out_mode_reg <= mode_reg;
            end
        end
    end

endmodule

// ----- sv/bvw_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Virtual wall port checker
// Checks sample/result timing and the held result seen at the top level ports.
// ----------------------------------------------------------------------------
module bvw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_x,
    input logic [1:0]  out_mode
);
    logic in_fire;

    assign in_fire = in_valid && in_ready;

    // A held result keeps its x force and wall mode stable.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_mode))
        else $error("result changed while stalled");

    // The unused mode code never appears.
    a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_mode != 2'd3)
        else $error("invalid wall mode reported");

    // Samples are processed one at a time.
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_fire)
        else $error("sample accepted in consecutive cycles");

    // A result never rises right after a sample is accepted.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_fire))
        else $error("result appeared too early");

endmodule

bind breakthrough_virtual_wall_force_top bvw_checker u_bvw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_x     (result.force_out_x),
    .out_mode  (result.mode_now)
);
